### rtl/rcwc_pkg.sv
// Shared types and constants for the Reno congestion window controller.
// No dependencies; rcwc_core and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package rcwc_pkg;

   // Default widths for the top level parameters
   localparam int SEQ_BITS_DEF    = 16;
   localparam int WINDOW_BITS_DEF = 10;

   // Fixed field widths
   localparam int CMD_W   = 2;
   localparam int CODE_W  = 2;
   localparam int BUF_W   = 6;
   localparam int CFG_W   = 10;
   localparam int REL_W   = 6;
   localparam int ACKS_W  = 10;
   localparam int DUP_W   = 8;
   localparam int CSR_IDX_W = 1;

   // Register reset values and limits
   localparam logic [BUF_W-1:0]  BUF_LIMIT_RST   = 6'd32;
   localparam logic [CFG_W-1:0]  INIT_THRESH_RST = 10'd16;
   localparam logic [BUF_W-1:0]  BUF_MAX         = 6'h3F;
   localparam logic [REL_W-1:0]  REL_MAX         = 6'h3F;
   localparam logic [ACKS_W-1:0] ACKS_MAX        = 10'h3FF;
   localparam logic [DUP_W-1:0]  DUP_MAX         = 8'hFF;
   localparam logic [DUP_W-1:0]  DUP_TRIGGER     = 8'd3;
   localparam int                RECOV_BOOST     = 3;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BUF_LIMIT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_THRESH = 1'b1;

   // Event kinds carried in tuser
   typedef enum logic [CMD_W-1:0] {
      CMD_SEND    = 2'd0,
      CMD_RX      = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_IDLE    = 2'd3
   } cmd_type;

   // Retransmit requests
   localparam logic [CODE_W-1:0] RETX_NONE   = 2'd0;
   localparam logic [CODE_W-1:0] RETX_OLDEST = 2'd1;
   localparam logic [CODE_W-1:0] RETX_WINDOW = 2'd2;

   // Timer commands
   localparam logic [CODE_W-1:0] TMR_LEAVE   = 2'd0;
   localparam logic [CODE_W-1:0] TMR_RESTART = 2'd1;
   localparam logic [CODE_W-1:0] TMR_STOP    = 2'd2;

   // Phase as reported on the result channel
   localparam logic [CODE_W-1:0] PHASE_CODE_SLOW  = 2'd0;
   localparam logic [CODE_W-1:0] PHASE_CODE_AVOID = 2'd1;
   localparam logic [CODE_W-1:0] PHASE_CODE_RECOV = 2'd2;

   // Congestion phase state machine
   typedef enum logic [2:0] {
      PH_SLOW  = 3'b001,
      PH_AVOID = 3'b010,
      PH_RECOV = 3'b100
   } phase_type;

endpackage

### rtl/rcwc_in_stage.sv
// Input register of the Reno window controller: holds one request transaction.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rcwc_in_stage #(
   parameter int DATA_W = 24,
   parameter int USER_W = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic [USER_W-1:0] req_tuser,
   input  logic              fire,
   output logic              item_valid,
   output logic [DATA_W-1:0] item_data,
   output logic [USER_W-1:0] item_user
);

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff;
   logic [USER_W-1:0] user_ff;
   logic              take;

   // Accept when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || fire;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on accept
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= req_tdata;
         user_ff <= req_tuser;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;
   assign item_user  = user_ff;

endmodule

### rtl/rcwc_core.sv
// Window state and single-pass update logic of the Reno window controller.
// Depends on rcwc_pkg.
`timescale 1ns / 1ps

module rcwc_core #(
   parameter int SEQ_BITS    = rcwc_pkg::SEQ_BITS_DEF,
   parameter int WINDOW_BITS = rcwc_pkg::WINDOW_BITS_DEF,
   parameter int DATA_W      = 24,
   parameter int RSP_W       = 56
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [rcwc_pkg::CMD_W-1:0]    item_user,
   input  logic [DATA_W-1:0]             item_data,
   input  logic                          csr_we,
   input  logic [rcwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcwc_pkg::CFG_W-1:0]    csr_wdata,
   output logic [RSP_W-1:0]              result
);

   localparam int S    = SEQ_BITS;
   localparam int W    = WINDOW_BITS;
   localparam int CMPW = S + W;
   localparam int SATW = rcwc_pkg::CFG_W + W;
   localparam logic [W-1:0] WMAX  = {W{1'b1}};
   localparam logic [W-1:0] W_ONE = W'(1);

   // Threshold load from a register write: zero reads as one, cap at WMAX
   function automatic logic [W-1:0] sat_cfg(input logic [rcwc_pkg::CFG_W-1:0] v);
      logic [rcwc_pkg::CFG_W-1:0] vv;
      vv = (v == '0) ? rcwc_pkg::CFG_W'(1) : v;
      if (SATW'(vv) > SATW'(WMAX)) begin
         return WMAX;
      end
      return W'(vv);
   endfunction

   localparam logic [W-1:0] SSTH_RST = sat_cfg(rcwc_pkg::INIT_THRESH_RST);

   // State
   logic [S-1:0]                    base_ff, base_in;
   logic [S-1:0]                    next_ff, next_in;
   logic [W-1:0]                    cwnd_ff, cwnd_in;
   logic [W-1:0]                    ssth_ff, ssth_in;
   rcwc_pkg::phase_type             phase_ff, phase_in;
   logic [rcwc_pkg::DUP_W-1:0]      dup_ff, dup_in;
   logic [rcwc_pkg::ACKS_W-1:0]     acks_ff, acks_in;
   logic [rcwc_pkg::BUF_W-1:0]      buflim_ff;

   // Item fields
   rcwc_pkg::cmd_type cmd;
   logic [S-1:0]      ack;
   logic              intact, ackf, rstf;

   // Shared terms
   logic [S-1:0]      outstanding, ack_next, ack_span;
   logic [CMPW-1:0]   usable;
   logic              fits, is_new, is_dup;
   logic [W-1:0]      cw_inc, half_raw, half, half_p3_sat;
   logic [W:0]        half_p3;
   logic [rcwc_pkg::ACKS_W-1:0] acks_inc;
   logic [rcwc_pkg::DUP_W-1:0]  dup_inc;
   logic [rcwc_pkg::REL_W-1:0]  released_cnt;

   // Result fields
   logic                        granted, peer;
   logic [S-1:0]                seq;
   logic [rcwc_pkg::CODE_W-1:0] retx, timer, phase_code;
   logic [rcwc_pkg::REL_W-1:0]  released;

   assign cmd    = rcwc_pkg::cmd_type'(item_user);
   assign ack    = item_data[S-1:0];
   assign intact = item_data[S];
   assign ackf   = item_data[S+1];
   assign rstf   = item_data[S+2];

   // Sequence space arithmetic, all modulo 2^S
   assign outstanding = next_ff - base_ff;
   assign ack_next    = ack + S'(1);
   assign ack_span    = ack_next - base_ff;
   assign usable      = (CMPW'(cwnd_ff) < CMPW'(buflim_ff)) ? CMPW'(cwnd_ff)
                                                            : CMPW'(buflim_ff);
   assign fits        = CMPW'(outstanding) < usable;
   assign is_new      = (ack_span != '0) && (ack_span <= outstanding);
   assign is_dup      = (ack_span == '0) && (outstanding != '0);
   assign released_cnt = (ack_span > S'(rcwc_pkg::REL_MAX)) ? rcwc_pkg::REL_MAX
                                                            : ack_span[rcwc_pkg::REL_W-1:0];

   // Window arithmetic
   assign cw_inc      = (cwnd_ff == WMAX) ? WMAX : cwnd_ff + W_ONE;
   assign half_raw    = cwnd_ff >> 1;
   assign half        = (half_raw == '0) ? W_ONE : half_raw;
   assign half_p3     = {1'b0, half} + (W+1)'(rcwc_pkg::RECOV_BOOST);
   assign half_p3_sat = (half_p3 > {1'b0, WMAX}) ? WMAX : half_p3[W-1:0];
   assign acks_inc    = (acks_ff == rcwc_pkg::ACKS_MAX) ? acks_ff
                                                        : acks_ff + rcwc_pkg::ACKS_W'(1);
   assign dup_inc     = (dup_ff == rcwc_pkg::DUP_MAX) ? dup_ff
                                                      : dup_ff + rcwc_pkg::DUP_W'(1);

   // Next state and result for the item in the input register
   always_comb begin
      logic [W-1:0] grown, grown_inc;
      base_in  = base_ff;
      next_in  = next_ff;
      cwnd_in  = cwnd_ff;
      ssth_in  = ssth_ff;
      phase_in = phase_ff;
      dup_in   = dup_ff;
      acks_in  = acks_ff;
      granted  = 1'b0;
      peer     = 1'b0;
      seq      = '0;
      retx     = rcwc_pkg::RETX_NONE;
      timer    = rcwc_pkg::TMR_LEAVE;
      released = '0;
      grown     = cwnd_ff;
      grown_inc = cw_inc;
      case (cmd)
         rcwc_pkg::CMD_SEND: begin
            if (fits) begin
               granted = 1'b1;
               seq     = next_ff;
               next_in = next_ff + S'(1);
               if (outstanding == '0) begin
                  timer = rcwc_pkg::TMR_RESTART;
               end
            end
         end
         rcwc_pkg::CMD_RX: begin
            if (intact && ackf) begin
               acks_in = acks_inc;
               if (is_new) begin
                  released = released_cnt;
                  base_in  = ack_next;
                  dup_in   = '0;
                  timer    = (ack_next == next_ff) ? rcwc_pkg::TMR_STOP
                                                   : rcwc_pkg::TMR_RESTART;
                  case (phase_ff)
                     rcwc_pkg::PH_SLOW: begin
                        cwnd_in = cw_inc;
                        if (cw_inc >= ssth_ff) begin
                           phase_in = rcwc_pkg::PH_AVOID;
                        end
                     end
                     default: begin
                        // Grow by one once a window's worth of ACKs is counted
                        if (CMPW'(acks_inc) >= CMPW'(cwnd_ff)) begin
                           grown   = cw_inc;
                           acks_in = '0;
                        end
                        grown_inc = (grown == WMAX) ? WMAX : grown + W_ONE;
                        cwnd_in   = grown;
                        // Deflate to at most the threshold and leave fast recovery
                        if (phase_ff == rcwc_pkg::PH_RECOV) begin
                           cwnd_in  = (grown_inc < ssth_ff) ? grown_inc : ssth_ff;
                           phase_in = rcwc_pkg::PH_AVOID;
                        end
                     end
                  endcase
               end else if (is_dup) begin
                  dup_in = dup_inc;
                  if (dup_inc == rcwc_pkg::DUP_TRIGGER) begin
                     ssth_in  = half;
                     cwnd_in  = half_p3_sat;
                     phase_in = rcwc_pkg::PH_RECOV;
                     retx     = rcwc_pkg::RETX_OLDEST;
                  end
               end
            end else if (intact && rstf) begin
               peer = 1'b1;
            end
         end
         rcwc_pkg::CMD_TIMEOUT: begin
            ssth_in  = half;
            cwnd_in  = W_ONE;
            phase_in = rcwc_pkg::PH_SLOW;
            dup_in   = '0;
            if (outstanding != '0) begin
               retx  = rcwc_pkg::RETX_WINDOW;
               timer = rcwc_pkg::TMR_RESTART;
            end else begin
               timer = rcwc_pkg::TMR_STOP;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      case (phase_in)
         rcwc_pkg::PH_SLOW:  phase_code = rcwc_pkg::PHASE_CODE_SLOW;
         rcwc_pkg::PH_AVOID: phase_code = rcwc_pkg::PHASE_CODE_AVOID;
         rcwc_pkg::PH_RECOV: phase_code = rcwc_pkg::PHASE_CODE_RECOV;
         default:            phase_code = rcwc_pkg::PHASE_CODE_SLOW;
      endcase
   end

   // Pack the result, granted in the lowest bit, zero padded to RSP_W
   assign result = RSP_W'({peer, released, phase_code, ssth_in, cwnd_in,
                           timer, retx, seq, granted});

   // Advance state on each item; register writes are to be made while idle, which the block itself does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= S'(1);
         next_ff   <= S'(1);
         cwnd_ff   <= W_ONE;
         ssth_ff   <= SSTH_RST;
         phase_ff  <= rcwc_pkg::PH_SLOW;
         dup_ff    <= '0;
         acks_ff   <= '0;
         buflim_ff <= rcwc_pkg::BUF_LIMIT_RST;
      end else begin
         if (fire) begin
            base_ff  <= base_in;
            next_ff  <= next_in;
            cwnd_ff  <= cwnd_in;
            ssth_ff  <= ssth_in;
            phase_ff <= phase_in;
            dup_ff   <= dup_in;
            acks_ff  <= acks_in;
         end
         if (csr_we) begin
            case (csr_index)
               rcwc_pkg::CSR_BUF_LIMIT:
                  buflim_ff <= csr_wdata[rcwc_pkg::BUF_W-1:0];
               rcwc_pkg::CSR_INIT_THRESH:
                  ssth_ff <= sat_cfg(csr_wdata);
               default: begin
               end
            endcase
         end
      end
   end

   // A granted send advances the next sequence number by exactly one
   a_grant_advance: assert property (@(posedge clock) disable iff (reset)
      fire && granted |=> next_ff == $past(next_ff) + S'(1))
      else $error("next sequence did not advance after a grant");

   // Window and threshold never collapse to zero
   a_cwnd_nonzero: assert property (@(posedge clock) disable iff (reset)
      cwnd_ff != '0)
      else $error("congestion window is zero");

   a_ssth_nonzero: assert property (@(posedge clock) disable iff (reset)
      ssth_ff != '0)
      else $error("slow start threshold is zero");

   // Outstanding count stays within the largest send buffer
   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      CMPW'(outstanding) <= CMPW'(rcwc_pkg::BUF_MAX))
      else $error("outstanding count exceeds send buffer");

   // Window moves only when an item is processed
   a_cwnd_hold: assert property (@(posedge clock) disable iff (reset)
      !fire |=> cwnd_ff == $past(cwnd_ff))
      else $error("congestion window changed without an item");

endmodule

### rtl/rcwc_out_stage.sv
// Result register of the Reno window controller: holds one response transaction.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module rcwc_out_stage #(
   parameter int RSP_W = 56
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  logic [RSP_W-1:0] result,
   output logic             space,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   logic             valid_ff, valid_in;
   logic [RSP_W-1:0] data_ff;

   // Room for a new result when empty or when the held one leaves now
   assign space = !valid_ff || rsp_tready;

   always_comb begin
      if (fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

### rtl/reno_congestion_window_control.sv
// Reno congestion window controller, sender side. Takes one event per clock
// while the response channel is ready (send request, received packet or timer
// expiry) and returns one result per event, in order. An event passes through
// an input register, one pass of window update logic and a result register,
// one event per cycle sustained while the response channel takes results. The
// input register lets a new event in while the previous result waits, if it is
// empty. Register writes take effect at once; there is no memory and no
// clearing pass after reset.
// Depends on rcwc_pkg, rcwc_in_stage, rcwc_core and rcwc_out_stage.
`timescale 1ns / 1ps

module reno_congestion_window_control #(
   parameter int SEQ_BITS    = rcwc_pkg::SEQ_BITS_DEF,
   parameter int WINDOW_BITS = rcwc_pkg::WINDOW_BITS_DEF,
   localparam int REQ_W = ((SEQ_BITS + 3 + 7) / 8) * 8,
   localparam int RSP_W = ((SEQ_BITS + 2 * WINDOW_BITS + 14 + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // ack_number, intact, ack_flag, reset_flag, zero pad
   input  logic [REQ_W-1:0]               req_tdata,
   // command
   input  logic [rcwc_pkg::CMD_W-1:0]     req_tuser,
   // Response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // send_granted, assigned_seq, retransmit, timer_action, window_now,
   // threshold_now, phase, released_count, peer_reset, zero pad
   output logic [RSP_W-1:0]               rsp_tdata,
   // Configuration writes
   input  logic                           csr_we,
   input  logic [rcwc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rcwc_pkg::CFG_W-1:0]     csr_wdata
);

   logic                       item_valid, space, fire;
   logic [REQ_W-1:0]           item_data;
   logic [rcwc_pkg::CMD_W-1:0] item_user;
   logic [RSP_W-1:0]           result;

   // Move the held item into the result register
   assign fire = item_valid && space;

   rcwc_in_stage #(
      .DATA_W(REQ_W),
      .USER_W(rcwc_pkg::CMD_W)
   ) u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .fire       (fire),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_user  (item_user)
   );

   rcwc_core #(
      .SEQ_BITS    (SEQ_BITS),
      .WINDOW_BITS (WINDOW_BITS),
      .DATA_W      (REQ_W),
      .RSP_W       (RSP_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item_user (item_user),
      .item_data (item_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (result)
   );

   rcwc_out_stage #(
      .RSP_W(RSP_W)
   ) u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .space      (space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
